// ===== hdl/strict_priority_multi_fifo_defines.svh =====
`ifndef STRICT_PRIORITY_MULTI_FIFO_DEFINES_SVH
`define STRICT_PRIORITY_MULTI_FIFO_DEFINES_SVH

// Checked while out of reset.
`define SPMF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SPMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/spmf_pkg.sv =====
package spmf_pkg;

    localparam int NUM_LEVELS_DEF  = 11;
    localparam int LEVEL_DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        ST_ENQUEUED = 3'd0,
        ST_FULL     = 3'd1,
        ST_BAD_PRIO = 3'd2,
        ST_DEQUEUED = 3'd3,
        ST_EMPTY    = 3'd4
    } spmf_status_t;

    typedef enum logic {
        MODE_ENQ = 1'b0,
        MODE_DEQ = 1'b1
    } spmf_mode_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [6:0]  age;
        logic [7:0]  sex;
    } spmf_entry_t;

    typedef struct packed {
        logic         served;
        spmf_status_t status;
        logic [3:0]   level;
    } spmf_res_t;

    typedef struct packed {
        logic we;
        logic re;
    } spmf_mem_ctl_t;

endpackage

// ===== hdl/spmf_req_if.sv =====
interface spmf_req_if import spmf_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        mode;
    logic [3:0]  priority_req;
    logic [15:0] payload_tag;
    logic [6:0]  age;
    logic [7:0]  sex_code;

    modport source (
        output valid, mode, priority_req, payload_tag, age, sex_code,
        input  ready
    );
    modport sink (
        input  valid, mode, priority_req, payload_tag, age, sex_code,
        output ready
    );
endinterface

// ===== hdl/spmf_rsp_if.sv =====
interface spmf_rsp_if import spmf_pkg::*; ();
    logic         valid;
    logic         ready;
    spmf_status_t status;
    logic [3:0]   served_level;
    logic [15:0]  out_tag;
    logic [6:0]   out_age;
    logic [7:0]   out_sex;

    modport source (
        output valid, status, served_level, out_tag, out_age, out_sex,
        input  ready
    );
    modport sink (
        input  valid, status, served_level, out_tag, out_age, out_sex,
        output ready
    );
endinterface

// ===== hdl/spmf_entry_ram.sv =====
module spmf_entry_ram import spmf_pkg::*; #(
    parameter int DEPTH = NUM_LEVELS_DEF * LEVEL_DEPTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic               clk,
    input  spmf_mem_ctl_t      ctl,
    input  logic [ADDR_W-1:0]  addr,
    input  spmf_entry_t        wdata,
    output spmf_entry_t        rdata
);

    spmf_entry_t mem [DEPTH];
    spmf_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/spmf_level_ctrl.sv =====
`include "strict_priority_multi_fifo_defines.svh"

module spmf_level_ctrl import spmf_pkg::*; #(
    parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
    localparam int ADDR_W = $clog2(NUM_LEVELS * LEVEL_DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               mode,
    input  logic [3:0]         prio,
    output spmf_res_t          res,
    output spmf_mem_ctl_t      mem_ctl,
    output logic [ADDR_W-1:0]  mem_addr
);

    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int SLOT_W = $clog2(LEVEL_DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int SUM_W  = SLOT_W + 1;

    logic [SLOT_W-1:0]   head_reg   [NUM_LEVELS];
    logic [SLOT_W-1:0]   head_next  [NUM_LEVELS];
    logic [CNT_W-1:0]    count_reg  [NUM_LEVELS];
    logic [CNT_W-1:0]    count_next [NUM_LEVELS];

    logic [NUM_LEVELS-1:0] nonempty;
    logic [LVL_W-1:0]      sel;
    logic                  any;
    logic                  bad;
    logic                  full;
    logic [LVL_W-1:0]      tgt;
    logic [SLOT_W-1:0]     cur_head;
    logic [CNT_W-1:0]      cur_cnt;
    logic [SUM_W-1:0]      tail_sum;
    logic [SUM_W-1:0]      head_sum;
    logic [SLOT_W-1:0]     tail;
    logic [SLOT_W-1:0]     head_inc;
    logic                  do_enq;
    logic                  do_deq;
    spmf_status_t          st;

    // Lowest-numbered non-empty level.
    always_comb
    begin
        sel = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            nonempty[l] = (count_reg[l] != '0);
            if (count_reg[l] != '0)
            begin
                sel = LVL_W'(l);
            end
        end
        any = (count_reg[sel] != '0);
    end

    assign bad = (32'(prio) >= NUM_LEVELS);

    always_comb
    begin
        if (mode == MODE_DEQ)
        begin
            tgt = sel;
        end
        else if (bad)
        begin
            tgt = '0;
        end
        else
        begin
            tgt = LVL_W'(prio);
        end
    end

    assign cur_head = head_reg[tgt];
    assign cur_cnt  = count_reg[tgt];
    assign full     = (cur_cnt == CNT_W'(LEVEL_DEPTH));

    assign tail_sum = SUM_W'(cur_head) + SUM_W'(cur_cnt);
    assign head_sum = SUM_W'(cur_head) + SUM_W'(1);
    assign tail     = (tail_sum >= SUM_W'(LEVEL_DEPTH))
                      ? SLOT_W'(tail_sum - SUM_W'(LEVEL_DEPTH)) : SLOT_W'(tail_sum);
    assign head_inc = (head_sum >= SUM_W'(LEVEL_DEPTH))
                      ? SLOT_W'(head_sum - SUM_W'(LEVEL_DEPTH)) : SLOT_W'(head_sum);

    always_comb
    begin
        if (mode == MODE_DEQ)
        begin
            st = any ? ST_DEQUEUED : ST_EMPTY;
        end
        else if (bad)
        begin
            st = ST_BAD_PRIO;
        end
        else if (full)
        begin
            st = ST_FULL;
        end
        else
        begin
            st = ST_ENQUEUED;
        end
    end

    assign do_enq = accept && (st == ST_ENQUEUED);
    assign do_deq = accept && (st == ST_DEQUEUED);

    assign mem_addr = ADDR_W'(tgt) * ADDR_W'(LEVEL_DEPTH)
                      + ADDR_W'((mode == MODE_DEQ) ? cur_head : tail);
    assign mem_ctl.we = do_enq;
    assign mem_ctl.re = do_deq;

    assign res.served = (st == ST_DEQUEUED);
    assign res.status = st;
    assign res.level  = (st == ST_DEQUEUED) ? 4'(sel) : 4'd0;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (do_enq)
        begin
            count_next[tgt] = cur_cnt + CNT_W'(1);
        end
        if (do_deq)
        begin
            count_next[tgt] = cur_cnt - CNT_W'(1);
            head_next[tgt]  = head_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    for (genvar g = 0; g < NUM_LEVELS; g++)
    begin : g_chk
        `SPMF_ASSERT(a_cnt_bound, clk, rst_n,
            count_reg[g] <= CNT_W'(LEVEL_DEPTH), "level count above depth")
    end

    `SPMF_ASSERT(a_deq_lowest, clk, rst_n,
        (do_deq |-> (nonempty & ~({NUM_LEVELS{1'b1}} << sel)) == '0),
        "dequeue skipped a more urgent level")

    `SPMF_ASSERT(a_enq_count, clk, rst_n,
        (do_enq |=> count_reg[$past(tgt)] == CNT_W'($past(cur_cnt) + CNT_W'(1))),
        "enqueue did not grow its level")

endmodule

// ===== hdl/strict_priority_multi_fifo.sv =====
// Strict-priority queue set: NUM_LEVELS FIFOs of LEVEL_DEPTH entries each.
// req channel: mode 0 appends (payload_tag, age, sex_code) to level
// priority_req; mode 1 pops the head of the most urgent non-empty level
// (level 0 first). rsp channel: exactly one status result per request,
// in request order; served_level and the entry fields are zero unless
// the status is dequeued. Bad priority, full level and all-empty cases
// change no state.
// Path: the entry RAM read and the read-stage result register s1 load at
// the accept edge; the output register loads from them once it is free.
// Throughput: one request per cycle unless rsp stalls; queue state is updated
// at the accept edge, so back-to-back requests see each other's effects.
// Stall: while rsp is held, one result waits in the read stage and one in
// the output register; req.ready drops until the output register drains.
// Reset: all levels empty, no result pending; entry RAM is not cleared
// and needs no sweep, since only written slots are ever read.
`include "strict_priority_multi_fifo_defines.svh"

module strict_priority_multi_fifo import spmf_pkg::*; #(
    parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    spmf_req_if.sink  req,
    spmf_rsp_if.source rsp
);

    localparam int DEPTH  = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              accept;
    logic              out_load;
    spmf_res_t         res;
    spmf_mem_ctl_t     mem_ctl;
    logic [ADDR_W-1:0] mem_addr;
    spmf_entry_t       wdata;
    spmf_entry_t       rdata;

    logic         s1_valid_reg, s1_valid_next;
    spmf_res_t    s1_res_reg, s1_res_next;
    logic         rsp_valid_reg, rsp_valid_next;
    spmf_status_t status_reg, status_next;
    logic [3:0]   level_reg, level_next;
    spmf_entry_t  entry_reg, entry_next;

    assign out_load  = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || out_load;
    assign accept    = req.valid && req.ready;

    assign wdata.tag = req.payload_tag;
    assign wdata.age = req.age;
    assign wdata.sex = req.sex_code;

    spmf_level_ctrl #(
        .NUM_LEVELS  (NUM_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .mode     (req.mode),
        .prio     (req.priority_req),
        .res      (res),
        .mem_ctl  (mem_ctl),
        .mem_addr (mem_addr)
    );

    spmf_entry_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_res_next    = s1_res_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        level_next     = level_reg;
        entry_next     = entry_reg;
        if (out_load)
        begin
            s1_valid_next  = 1'b0;
            rsp_valid_next = 1'b1;
            status_next    = s1_res_reg.status;
            level_next     = s1_res_reg.level;
            entry_next     = s1_res_reg.served ? rdata : '0;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_res_reg <= s1_res_next;
        status_reg <= status_next;
        level_reg  <= level_next;
        entry_reg  <= entry_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.served_level = level_reg;
    assign rsp.out_tag      = entry_reg.tag;
    assign rsp.out_age      = entry_reg.age;
    assign rsp.out_sex      = entry_reg.sex;

    `SPMF_ASSERT(a_acc_pending, clk, rst_n,
        (accept |=> s1_valid_reg), "accepted request left no pending result")

    `SPMF_ASSERT(a_no_overrun, clk, rst_n,
        ((s1_valid_reg && !out_load) |-> !accept), "read stage overwritten")

    `SPMF_ASSERT(a_zero_fields, clk, rst_n,
        ((rsp.valid && rsp.status != ST_DEQUEUED) |->
            (rsp.served_level == 4'd0 && rsp.out_tag == 16'd0 &&
             rsp.out_age == 7'd0 && rsp.out_sex == 8'd0)),
        "non-dequeue result carries entry data")

    `SPMF_ASSERT_ALWAYS(a_reset_idle, clk,
        (!rst_n |=> (!rsp.valid && !s1_valid_reg)), "result pending in reset")

endmodule
